@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the open-list heap.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define AOLH_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define AOLH_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/aolh_pkg.sv @@
// Types, codes and constants of the open-list heap.
// No dependencies; used by aolh_core and astar_open_list_heap_unit.
package aolh_pkg;

	localparam int HANDLE_W         = 16;
	localparam int COST_W           = 24;
	localparam int PRIO_W           = 25;
	localparam int COUNT_W          = 7;
	localparam int CAPACITY_DEF     = 64;
	localparam int HANDLE_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_HAS = 2'd2,
		FUNC_CLR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		func_t                 func;
		logic [HANDLE_W-1:0]   node_handle;
		logic [COST_W-1:0]     cost_so_far;
		logic [COST_W-1:0]     heuristic_cost;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]   served_handle;
		logic [PRIO_W-1:0]     served_priority;
		logic                  found;
		logic [COUNT_W-1:0]    entry_count;
		logic                  is_empty;
		status_t               status;
	} rsp_t;

	// Operation handed to the core.
	typedef struct packed {
		func_t                 func;
		logic [HANDLE_W-1:0]   handle;
		logic [PRIO_W-1:0]     prio;
	} cmd_t;

	// Core handshake toward the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

endpackage

@@ rtl/aolh_core.sv @@
// Heap sequencer: entry memory, priority compares, sift-up/down and scan.
// Depends on aolh_pkg.
module aolh_core import aolh_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cmd_t       cmd,
	input  logic       slot_free,
	output core_stat_t stat,
	output rsp_t       result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;
	localparam int SH = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);

	typedef struct packed {
		logic [SH-1:0]     handle;
		logic [PRIO_W-1:0] prio;
	} ent_t;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_UP_RD  = 9'b000000010,
		S_UP_CMP = 9'b000000100,
		S_DQ_RD  = 9'b000001000,
		S_DQ_LD  = 9'b000010000,
		S_DN_RD  = 9'b000100000,
		S_DN_CMP = 9'b001000000,
		S_SCAN   = 9'b010000000,
		S_RESP   = 9'b100000000
	} state_t;

	ent_t mem [CAPACITY];

	state_t            state_q;
	logic [CW-1:0]     n_q;
	logic [AW-1:0]     hole_q;
	ent_t              x_q;
	logic [SH-1:0]     key_q;
	logic [CW-1:0]     idx_q;
	logic              pend_q;
	logic [SH-1:0]     srv_h_q;
	logic [PRIO_W-1:0] srv_p_q;
	logic              found_q;
	status_t           status_q;
	ent_t              rd_a_q;
	ent_t              rd_b_q;

	logic [AW-1:0] parent;
	logic [IW-1:0] lft;
	logic [IW-1:0] rgt;
	logic [IW-1:0] n_ext;
	logic          take_r;
	ent_t          best;
	logic [AW-1:0] best_idx;
	logic          hit;
	logic          we;
	logic [AW-1:0] wa;
	ent_t          wd;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;

	assign parent   = (hole_q - AW'(1)) >> 1;
	assign lft      = (IW'(hole_q) << 1) + IW'(1);
	assign rgt      = lft + IW'(1);
	assign n_ext    = IW'(n_q);
	assign take_r   = (rgt < n_ext) && (rd_b_q.prio < rd_a_q.prio);
	assign best     = take_r ? rd_b_q : rd_a_q;
	assign best_idx = take_r ? rgt[AW-1:0] : lft[AW-1:0];
	assign hit      = pend_q && (rd_a_q.handle == key_q);

	always_comb begin
		we        = 1'b0;
		wa        = hole_q;
		wd        = x_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (state_q)
			S_UP_RD: begin
				rd_addr_a = parent;
				we        = (hole_q == '0);
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (rd_a_q.prio > x_q.prio) begin
					wd = rd_a_q;
				end
			end
			S_DQ_RD: begin
				rd_addr_b = AW'(n_q - CW'(1));
			end
			S_DN_RD: begin
				rd_addr_a = lft[AW-1:0];
				rd_addr_b = rgt[AW-1:0];
				we        = (lft >= n_ext);
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (best.prio < x_q.prio) begin
					wd = best;
				end
			end
			S_SCAN: begin
				rd_addr_a = idx_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			hole_q   <= '0;
			x_q      <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			pend_q   <= 1'b0;
			srv_h_q  <= '0;
			srv_p_q  <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						found_q  <= 1'b0;
						srv_h_q  <= '0;
						srv_p_q  <= '0;
						case (cmd.func)
							FUNC_ENQ: begin
								if (n_q == CAP_N) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									x_q.handle <= cmd.handle[SH-1:0];
									x_q.prio   <= cmd.prio;
									hole_q     <= n_q[AW-1:0];
									n_q        <= n_q + CW'(1);
									state_q    <= S_UP_RD;
								end
							end
							FUNC_DEQ: begin
								if (n_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_DQ_RD;
								end
							end
							FUNC_HAS: begin
								key_q   <= cmd.handle[SH-1:0];
								idx_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= S_SCAN;
							end
							FUNC_CLR: begin
								n_q     <= '0;
								state_q <= S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_UP_RD: begin
					state_q <= (hole_q == '0) ? S_RESP : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (rd_a_q.prio > x_q.prio) begin
						hole_q  <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_DQ_RD: begin
					state_q <= S_DQ_LD;
				end
				S_DQ_LD: begin
					srv_h_q <= rd_a_q.handle;
					srv_p_q <= rd_a_q.prio;
					x_q     <= rd_b_q;
					n_q     <= n_q - CW'(1);
					hole_q  <= '0;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= (lft >= n_ext) ? S_RESP : S_DN_CMP;
				end
				S_DN_CMP: begin
					if (best.prio < x_q.prio) begin
						hole_q  <= best_idx;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_RESP;
					end else if (idx_q < n_q) begin
						idx_q  <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_RESP) && slot_free;

	assign result.served_handle   = HANDLE_W'(srv_h_q);
	assign result.served_priority = srv_p_q;
	assign result.found           = found_q;
	assign result.entry_count     = COUNT_W'(n_q);
	assign result.is_empty        = (n_q == '0);
	assign result.status          = status_q;

endmodule

@@ rtl/astar_open_list_heap_unit.sv @@
// Top level of the open-list heap: request decode, priority adder, result register.
// Depends on aolh_pkg, aolh_core and assert_macros.svh.

// Open list for path search kept as a binary min-heap of CAPACITY entries in a
// two-read, one-write memory with registered reads. One request is worked at a
// time; req_ready is high only while the sequencer is idle. Each heap level takes
// a read state and a compare state: enqueue climbs levels from the new last slot,
// dequeue first reads the root and the last entry and then sinks levels, contains
// reads the held entries in turn, clear walks no level; each then hands the word to
// the result register from the response state. The next request is taken while a
// result word waits on rsp_ready. Memory contents are not reset; only slots below
// the count are ever used.
`include "assert_macros.svh"

module astar_open_list_heap_unit import aolh_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	core_stat_t stat;
	cmd_t       cmd;
	rsp_t       result;
	logic       start;
	logic       slot_free;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	assign req_ready = stat.idle;
	assign start     = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign cmd.func   = req.func;
	assign cmd.handle = req.node_handle;
	assign cmd.prio   = PRIO_W'(req.cost_so_far) + PRIO_W'(req.heuristic_cost);

	aolh_core #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.slot_free (slot_free),
		.stat      (stat),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`AOLH_ASSERT_NXT(a_busy_after_take, start, !req_ready, "request taken while busy")
	`AOLH_ASSERT_IMP(a_empty_deq, rsp_valid && rsp.status == ST_EMPTY, rsp.is_empty && rsp.served_priority == '0 && rsp.served_handle == '0, "empty dequeue served data")
	`AOLH_ASSERT_IMP(a_found_ok, rsp_valid && rsp.found, rsp.status == ST_OK && rsp.served_handle == '0, "hit with bad status")
	`AOLH_ASSERT_IMP(a_full_nonempty, rsp_valid && rsp.status == ST_FULL, !rsp.is_empty, "full flagged while empty")

endmodule
